// ===== hw/rtl/tdbe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tdbe_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] HDR_OBJECT  = 8'h80;
  localparam logic [7:0] HDR_SUBJECT = 8'hC0;
  localparam logic [31:0] SMALL_GAP  = 32'd128;

  // number of value fields that follow the header
  localparam logic [1:0] NV_NONE  = 2'd0;
  localparam logic [1:0] NV_ONE   = 2'd1;
  localparam logic [1:0] NV_TWO   = 2'd2;
  localparam logic [1:0] NV_THREE = 2'd3;

  typedef struct packed {
    logic [7:0]       header;
    logic [1:0]       nv;
    logic [2:0][1:0]  len;
    logic [2:0][31:0] val;
  } tdbe_pkt_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_HEADER,
    BK_VALUE
  } tdbe_bk_state_t;

  // byte length minus one of the shortest big-endian form of v
  function automatic logic [1:0] len_code(input logic [31:0] v);
    logic [1:0] code;
    if (v[31:24] != 8'd0) begin
      code = 2'd3;
    end else if (v[23:16] != 8'd0) begin
      code = 2'd2;
    end else if (v[15:8] != 8'd0) begin
      code = 2'd1;
    end else begin
      code = 2'd0;
    end
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tdbe_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tdbe_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [31:0]         subject_id,
  input  wire logic [31:0]         predicate_id,
  input  wire logic [31:0]         object_id,
  output logic                     q_push,
  input  wire logic                q_ready,
  output tdbe_pkg::tdbe_pkt_t      q_data
);

  logic [31:0] prev_subject;
  logic [31:0] prev_predicate;
  logic [31:0] prev_object;

  logic        s_eq;
  logic        p_eq;
  logic        o_eq;
  logic        dup;
  logic [31:0] sg;
  logic [31:0] pg;
  logic [31:0] og;
  logic [31:0] og_rem;
  logic [1:0]  lc_s;
  logic [1:0]  lc_p;
  logic [1:0]  lc_o;
  logic [1:0]  lc_pg;
  logic [1:0]  lc_rem;
  logic [2:0]  pg_len;

  assign s_eq   = subject_id == prev_subject;
  assign p_eq   = predicate_id == prev_predicate;
  assign o_eq   = object_id == prev_object;
  assign dup    = s_eq && p_eq && o_eq;
  assign sg     = subject_id - prev_subject;
  assign pg     = predicate_id - prev_predicate;
  assign og     = object_id - prev_object;
  assign og_rem = og - tdbe_pkg::SMALL_GAP;
  assign lc_s   = tdbe_pkg::len_code(sg);
  assign lc_p   = tdbe_pkg::len_code(predicate_id);
  assign lc_o   = tdbe_pkg::len_code(object_id);
  assign lc_pg  = tdbe_pkg::len_code(pg);
  assign lc_rem = tdbe_pkg::len_code(og_rem);
  // predicate-gap length goes into the header unreduced
  assign pg_len = {1'b0, lc_pg} + 3'd1;

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready && !dup;

  always_comb begin
    q_data     = '0;
    if (!s_eq) begin
      q_data.header = tdbe_pkg::HDR_SUBJECT | {2'b00, lc_s, lc_p, lc_o};
      q_data.nv     = tdbe_pkg::NV_THREE;
      q_data.len    = {lc_o, lc_p, lc_s};
      q_data.val    = {object_id, predicate_id, sg};
    end else if (!p_eq) begin
      q_data.header = tdbe_pkg::HDR_OBJECT | {3'b000, pg_len, lc_o};
      q_data.nv     = tdbe_pkg::NV_TWO;
      q_data.len    = {2'd0, lc_o, lc_pg};
      q_data.val    = {32'd0, object_id, pg};
    end else if (og < tdbe_pkg::SMALL_GAP) begin
      q_data.header = og[7:0];
      q_data.nv     = tdbe_pkg::NV_NONE;
    end else begin
      q_data.header = tdbe_pkg::HDR_OBJECT | {6'd0, lc_rem};
      q_data.nv     = tdbe_pkg::NV_ONE;
      q_data.len    = {2'd0, 2'd0, lc_rem};
      q_data.val    = {32'd0, 32'd0, og_rem};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_subject   <= '0;
      prev_predicate <= '0;
      prev_object    <= '0;
    end else if (q_push) begin
      prev_subject   <= subject_id;
      prev_predicate <= predicate_id;
      prev_object    <= object_id;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tdbe_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tdbe_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire tdbe_pkg::tdbe_pkt_t push_data,
  output logic                     push_ready,
  output logic                     pop_valid,
  input  wire logic                pop_ready,
  output tdbe_pkg::tdbe_pkt_t      pop_data,
  output logic                     full
);

  localparam int unsigned PtrW = (tdbe_pkg::QUEUE_DEPTH > 1) ?
                                 $clog2(tdbe_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(tdbe_pkg::QUEUE_DEPTH + 1);

  tdbe_pkg::tdbe_pkt_t mem [tdbe_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            pop;

  assign full       = count == CntW'(tdbe_pkg::QUEUE_DEPTH);
  assign push_ready = !full;
  assign pop_valid  = count != '0;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(tdbe_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(tdbe_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tdbe_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tdbe_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  output logic                     q_ready,
  input  wire tdbe_pkg::tdbe_pkt_t q_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_byte,
  output logic                     last_byte
);

  tdbe_pkg::tdbe_bk_state_t state;
  tdbe_pkg::tdbe_bk_state_t state_next;
  tdbe_pkg::tdbe_pkt_t      pkt;
  logic [1:0]               vsel;
  logic [1:0]               bsel;

  logic        advance;
  logic        emit;
  logic        is_last;
  logic [7:0]  byte_sel;
  logic [31:0] cur_val;
  logic [31:0] shifted;
  logic [1:0]  vsel_inc;

  assign advance  = !out_valid || out_ready;
  assign cur_val  = pkt.val[vsel];
  assign shifted  = cur_val >> {bsel, 3'b000};
  assign vsel_inc = vsel + 2'd1;

  // output decode
  always_comb begin
    emit     = 1'b0;
    is_last  = 1'b0;
    byte_sel = pkt.header;
    q_ready  = 1'b0;
    unique case (state)
      tdbe_pkg::BK_IDLE: begin
        q_ready = 1'b1;
      end
      tdbe_pkg::BK_HEADER: begin
        emit     = advance;
        is_last  = pkt.nv == tdbe_pkg::NV_NONE;
        byte_sel = pkt.header;
        q_ready  = emit && is_last;
      end
      tdbe_pkg::BK_VALUE: begin
        emit     = advance;
        is_last  = (vsel == pkt.nv - 2'd1) && (bsel == 2'd0);
        byte_sel = shifted[7:0];
        q_ready  = emit && is_last;
      end
      default: begin
        q_ready = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tdbe_pkg::BK_IDLE: begin
        if (q_valid) begin
          state_next = tdbe_pkg::BK_HEADER;
        end
      end
      tdbe_pkg::BK_HEADER, tdbe_pkg::BK_VALUE: begin
        if (emit) begin
          if (is_last) begin
            state_next = q_valid ? tdbe_pkg::BK_HEADER : tdbe_pkg::BK_IDLE;
          end else begin
            state_next = tdbe_pkg::BK_VALUE;
          end
        end
      end
      default: begin
        state_next = tdbe_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tdbe_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working word and byte cursor
  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      pkt  <= q_data;
      vsel <= 2'd0;
      bsel <= q_data.len[0];
    end else if (emit && state == tdbe_pkg::BK_VALUE) begin
      if (bsel == 2'd0) begin
        vsel <= vsel_inc;
        bsel <= pkt.len[vsel_inc];
      end else begin
        bsel <= bsel - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte  <= byte_sel;
      last_byte <= is_last;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/triple_delta_byte_encoder_unit.sv =====
// Triple delta byte encoder.
// Input channel (in_valid/in_ready) takes one sorted triple per word:
// subject_id, predicate_id, object_id. Output channel (out_valid/out_ready)
// gives the compressed stream one byte per word, last_byte marking the
// final byte of a triple. A duplicate triple produces no output.
// The front compares each triple against the previous one in the cycle it
// is accepted and pushes a coded packet into a two-entry queue; the back
// serializes packets through a registered output, one byte per cycle while
// out_ready holds. A triple passes from the queue into the back's packet
// register and then out through the output register. A triple takes 1 to
// 13 bytes of the output stream; a triple arriving into an idle back first
// passes through the idle state for the packet load.
// The input takes a new triple every cycle while the queue has room.
// Reset clears the previous triple to all zeros and empties the queue
// and output register. When the receiver stalls, the output word holds,
// the queue fills and in_ready drops after two coded triples are waiting.
`timescale 1ns / 1ps
`default_nettype none

module triple_delta_byte_encoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] subject_id,
  input  wire logic [31:0] predicate_id,
  input  wire logic [31:0] object_id,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             last_byte
);

  logic                q_push;
  logic                q_push_ready;
  logic                q_valid;
  logic                q_ready;
  logic                q_full;
  tdbe_pkg::tdbe_pkt_t q_wdata;
  tdbe_pkg::tdbe_pkt_t q_rdata;

  tdbe_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .subject_id   (subject_id),
    .predicate_id (predicate_id),
    .object_id    (object_id),
    .q_push       (q_push),
    .q_ready      (q_push_ready),
    .q_data       (q_wdata)
  );

  tdbe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_wdata),
    .push_ready (q_push_ready),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_rdata),
    .full       (q_full)
  );

  tdbe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last_byte (last_byte)
  );

  // no push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("push into full queue");

  // reset empties the queue and the output register
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !q_valid)
    else $error("state left after reset");

  // a full queue with no pop stays full and keeps the input stalled
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    q_full && !q_ready |=> q_full && !in_ready)
    else $error("full queue lost an entry");

endmodule

`default_nettype wire
